@@ rtl/ttmc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttmc_pkg - shared types and constants
// Word formats, sorter cell types, controller states and register indexes.
// ----------------------------------------------------------------------------
package ttmc_pkg;

  localparam int ADC_W  = 12;
  localparam int GAIN_W = 16;
  localparam int OFS_W  = 12;
  localparam int XY_W   = 16;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 16;
  localparam int FRAC_W = 14;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_X_GAIN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_OFFSET = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_GAIN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_OFFSET = 3'd3;
  localparam logic [IDX_W-1:0] REG_AGREE    = 3'd4;

  // register reset values
  localparam logic [GAIN_W-1:0]       X_GAIN_RST   = 16'd4245;
  localparam logic signed [OFS_W-1:0] X_OFFSET_RST = -12'sd20;
  localparam logic [GAIN_W-1:0]       Y_GAIN_RST   = 16'd2592;
  localparam logic signed [OFS_W-1:0] Y_OFFSET_RST = -12'sd38;
  localparam logic [ADC_W-1:0]        AGREE_RST    = 12'd50;

  // sample groups of one sequence
  localparam logic [1:0] GRP_X1 = 2'd0;
  localparam logic [1:0] GRP_Y1 = 2'd1;
  localparam logic [1:0] GRP_X2 = 2'd2;
  localparam logic [1:0] GRP_Y2 = 2'd3;

  typedef struct packed {
    logic [ADC_W-1:0] adc_sample;
    logic             start_req;
  } in_t;

  typedef struct packed {
    logic                   agree;
    logic [ADC_W-1:0]       x_adc;
    logic [ADC_W-1:0]       y_adc;
    logic signed [XY_W-1:0] x_pos;
    logic signed [XY_W-1:0] y_pos;
  } out_t;

  // one sorter cell: empty cells count as larger than any sample
  typedef struct packed {
    logic             vld;
    logic [ADC_W-1:0] val;
  } cell_t;

  typedef struct packed {
    logic ins;    // insert the broadcast sample
    logic first;  // first sample of a group: empty the chain
    logic shift;  // move every cell one place up
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_DRAIN,
    S_DSTART,
    S_DIV,
    S_CAL1,
    S_CAL2,
    S_OUT
  } state_t;

endpackage

@@ rtl/ttmc_cell.sv @@
// ----------------------------------------------------------------------------
// ttmc_cell - insertion sorter cell
// Holds one sample; the chain stays sorted ascending from the head cell.
// ----------------------------------------------------------------------------
module ttmc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              head,
  input  ttmc_pkg::cell_ctl_t ctl,
  input  logic [11:0]       sample,
  input  ttmc_pkg::cell_t   prev,
  output ttmc_pkg::cell_t   cur
);
  import ttmc_pkg::*;

  cell_t held;
  cell_t held_next;
  logic  prev_gt;
  logic  me_gt;

  // an empty lower neighbour is larger than anything (never for the head)
  assign prev_gt = head ? 1'b0 : (!prev.vld || (prev.val > sample));
  assign me_gt   = !held.vld || (held.val > sample);

  always_comb begin
    held_next = held;
    if (ctl.shift) begin
      held_next = prev;
    end else if (ctl.ins) begin
      if (ctl.first) begin
        held_next.vld = head;
        held_next.val = sample;
      end else if (prev_gt) begin
        held_next = prev;
      end else if (me_gt) begin
        held_next.vld = 1'b1;
        held_next.val = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    held.val <= held_next.val;
    if (rst) begin
      held.vld <= 1'b0;
    end else begin
      held.vld <= held_next.vld;
    end
  end

  assign cur = held;

endmodule

@@ rtl/ttmc_div.sv @@
// ----------------------------------------------------------------------------
// ttmc_div - division by a fixed divisor
// Reciprocal multiply and shift, exact for any NW-bit dividend; the quotient
// is registered and ready, with done, in the cycle after start.
// ----------------------------------------------------------------------------
module ttmc_div #(
  parameter int NW  = 17,
  parameter int DIV = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  output logic [NW-1:0] quotient,
  output logic          done
);
  // shift of NW + ceil(log2 DIV) keeps the rounded-up reciprocal exact
  localparam int     SH    = NW + $clog2(DIV);
  localparam int     MW    = NW + 1;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIV) - 1) / longint'(DIV);
  localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

  logic [NW+MW-1:0] prod;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= {{MW{1'b0}}, dividend} * {{NW{1'b0}}, RECIP_V};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  assign quotient = NW'(prod >> SH);

endmodule

@@ rtl/ttmc_calib.sv @@
// ----------------------------------------------------------------------------
// ttmc_calib - linear position calibration
// gain * adc in Q2.14 plus offset, truncated toward zero, saturated; 2 stages.
// ----------------------------------------------------------------------------
module ttmc_calib (
  input  logic               clk,
  input  logic [15:0]        gain,
  input  logic signed [11:0] offset,
  input  logic [11:0]        adc,
  output logic signed [15:0] pos
);
  import ttmc_pkg::*;

  localparam int TW = 31;

  logic [27:0]        prod;
  logic signed [11:0] ofs_q;
  logic signed [TW-1:0] tot;
  logic signed [TW-1:0] adj;
  logic signed [16:0]   q;
  logic signed [15:0]   sat;

  always_ff @(posedge clk) begin
    prod  <= gain * adc;
    ofs_q <= offset;
  end

  always_comb begin
    tot = $signed({3'b000, prod}) + $signed({{5{ofs_q[11]}}, ofs_q, {FRAC_W{1'b0}}});
    // negative totals round toward zero
    adj = tot[TW-1] ? tot + TW'(16383) : tot;
    q   = adj[TW-1:FRAC_W];
    if (q[16] != q[15]) begin
      sat = q[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    pos <= sat;
  end

endmodule

@@ rtl/touch_trimmed_mean_calibrate.sv @@
// ----------------------------------------------------------------------------
// touch_trimmed_mean_calibrate - touch sample trimmed mean and calibration
// Throughput: within a group one word is taken per cycle; after each group's
//   last word input stalls while the cell chain drains, the divider is started
//   and the reciprocal divide completes.
// After the fourth group input further stalls through the calibration states
//   and the load of the result into the output register.
// Input also stalls while a new result waits on a full output register.
// Reset (rst, synchronous): chain emptied, sequence restarts, registers default.
// ----------------------------------------------------------------------------
module touch_trimmed_mean_calibrate #(
  parameter int SAMPLES = 10,
  parameter int TRIM    = 4
) (
  input  logic                clk,
  input  logic                rst,
  // sample words
  input  logic                in_valid,
  output logic                in_stall,
  input  ttmc_pkg::in_t       in_data,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output ttmc_pkg::out_t      out_data,
  // register writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import ttmc_pkg::*;

  // trim is clipped so that at least one sample survives
  localparam int EFF_TRIM = (2 * TRIM >= SAMPLES) ? ((SAMPLES - 1) / 2) : TRIM;
  localparam int KEPT     = SAMPLES - 2 * EFF_TRIM;
  localparam int SUM_W    = $clog2(SAMPLES * 4095 + 1);
  localparam int PW       = $clog2(SAMPLES);
  localparam logic [PW-1:0] LAST_POS  = PW'(SAMPLES - 1);
  localparam logic [PW-1:0] KEEP_LO   = PW'(EFF_TRIM);
  localparam logic [PW-1:0] KEEP_LAST = PW'(SAMPLES - EFF_TRIM - 1);

  // configuration registers
  logic [GAIN_W-1:0]       x_gain;
  logic signed [OFS_W-1:0] x_offset;
  logic [GAIN_W-1:0]       y_gain;
  logic signed [OFS_W-1:0] y_offset;
  logic [ADC_W-1:0]        agree_range;

  // control state
  state_t          state;
  state_t          state_next;
  logic [PW-1:0]   pos;
  logic [1:0]      grp;
  logic [PW-1:0]   dcnt;

  // datapath
  logic [SUM_W-1:0] acc;
  logic [ADC_W-1:0] first_x;
  logic [ADC_W-1:0] first_y;
  logic [ADC_W-1:0] second_x;
  logic [ADC_W-1:0] x_avg;
  logic [ADC_W-1:0] y_avg;
  logic             agree;

  logic             in_acc;
  logic [PW-1:0]    cur_pos;
  logic [1:0]       cur_grp;
  cell_ctl_t        ctl;
  cell_t            chain [SAMPLES+1];
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quo;
  logic [ADC_W-1:0] mean;
  logic [ADC_W-1:0] dx;
  logic [ADC_W-1:0] dy;
  logic [ADC_W:0]   sx;
  logic [ADC_W:0]   sy;
  logic signed [XY_W-1:0] x_cal;
  logic signed [XY_W-1:0] y_cal;

  // output register
  logic             res_load;
  logic             out_full;
  out_t             out_word;
  out_t             out_word_next;

  // ---------------------------------------------------------------------------
  // Register port: always ready, unknown indexes dropped
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_gain      <= X_GAIN_RST;
      x_offset    <= X_OFFSET_RST;
      y_gain      <= Y_GAIN_RST;
      y_offset    <= Y_OFFSET_RST;
      agree_range <= AGREE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_GAIN:   x_gain      <= cfg_data;
        REG_X_OFFSET: x_offset    <= cfg_data[OFS_W-1:0];
        REG_Y_GAIN:   y_gain      <= cfg_data;
        REG_Y_OFFSET: y_offset    <= cfg_data[OFS_W-1:0];
        REG_AGREE:    agree_range <= cfg_data[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: a restart request makes this word the first X sample
  // ---------------------------------------------------------------------------
  assign in_acc  = in_valid && !in_stall;
  assign cur_pos = in_data.start_req ? '0 : pos;
  assign cur_grp = in_data.start_req ? GRP_X1 : grp;

  always_comb begin
    state_next = state;
    case (state)
      S_FILL:   if (in_acc && cur_pos == LAST_POS) state_next = S_DRAIN;
      S_DRAIN:  if (dcnt == LAST_POS) state_next = S_DSTART;
      S_DSTART: state_next = S_DIV;
      S_DIV:    if (div_done) state_next = (grp == GRP_Y2) ? S_CAL1 : S_FILL;
      S_CAL1:   state_next = S_CAL2;
      S_CAL2:   state_next = S_OUT;
      S_OUT:    if (res_load) state_next = S_FILL;
      default:  state_next = S_FILL;
    endcase
  end

  // S_OUT waits only while the output register still holds an untaken word
  always_comb begin
    in_stall  = (state != S_FILL);
    out_valid = out_full;
    res_load  = (state == S_OUT) && (!out_full || !out_stall);
    div_start = (state == S_DSTART);
    ctl.ins   = in_valid && (state == S_FILL);
    ctl.first = in_valid && (state == S_FILL) && (cur_pos == '0);
    ctl.shift = (state == S_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      pos   <= '0;
      grp   <= GRP_X1;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        grp <= cur_grp;
        pos <= (cur_pos == LAST_POS) ? '0 : cur_pos + 1'b1;
      end
      if (state == S_DRAIN) begin
        dcnt <= (dcnt == LAST_POS) ? '0 : dcnt + 1'b1;
      end
      if (state == S_DIV && div_done) begin
        grp <= (grp == GRP_Y2) ? GRP_X1 : grp + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sorter chain: head is cell 0 (smallest); the drain shifts upwards and
  // reads the top cell, so the kept window is symmetric either way round
  // ---------------------------------------------------------------------------
  assign chain[0] = '0;

  for (genvar i = 0; i < SAMPLES; i++) begin : g_cell
    ttmc_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .head   (i == 0),
      .ctl    (ctl),
      .sample (in_data.adc_sample),
      .prev   (chain[i]),
      .cur    (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (in_acc && cur_pos == LAST_POS) begin
      acc <= '0;
    end else if (state == S_DRAIN && dcnt >= KEEP_LO && dcnt <= KEEP_LAST) begin
      acc <= acc + SUM_W'(chain[SAMPLES].val);
    end
  end

  // ---------------------------------------------------------------------------
  // Mean of the kept samples
  // ---------------------------------------------------------------------------
  ttmc_div #(
    .NW  (SUM_W),
    .DIV (KEPT)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .quotient (quo),
    .done     (div_done)
  );

  assign mean = quo[ADC_W-1:0];

  // agreement check and pair averages, once the second Y mean is in
  assign dx = (first_x > second_x) ? first_x - second_x : second_x - first_x;
  assign dy = (first_y > mean) ? first_y - mean : mean - first_y;
  assign sx = {1'b0, first_x} + {1'b0, second_x};
  assign sy = {1'b0, first_y} + {1'b0, mean};

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      case (grp)
        GRP_X1: first_x  <= mean;
        GRP_Y1: first_y  <= mean;
        GRP_X2: second_x <= mean;
        default: begin
          agree <= (dx < agree_range) && (dy < agree_range);
          x_avg <= sx[ADC_W:1];
          y_avg <= sy[ADC_W:1];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Calibration, two stages per axis
  // ---------------------------------------------------------------------------
  ttmc_calib u_cal_x (
    .clk    (clk),
    .gain   (x_gain),
    .offset (x_offset),
    .adc    (x_avg),
    .pos    (x_cal)
  );

  ttmc_calib u_cal_y (
    .clk    (clk),
    .gain   (y_gain),
    .offset (y_offset),
    .adc    (y_avg),
    .pos    (y_cal)
  );

  // result word: all fields zero when the readings disagree
  always_comb begin
    out_word_next.agree = agree;
    out_word_next.x_adc = agree ? x_avg : '0;
    out_word_next.y_adc = agree ? y_avg : '0;
    out_word_next.x_pos = agree ? x_cal : '0;
    out_word_next.y_pos = agree ? y_cal : '0;
  end

  // output register frees the sample side while a word waits downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_load) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_word <= out_word_next;
    end
  end

  assign out_data = out_word;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - touch trimmed-mean calibrate testbench
// Sends sequences of X/Y sample words, mostly well formed with random content,
// plus broken and restarted ones, across several register settings. A local
// model of the filter and calibration predicts each result word, and every
// word taken from the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ttmc_pkg::*;

  localparam int SAMPLES  = 10;
  localparam int TRIM     = 4;
  // trim is capped so at least one sample is kept
  localparam int CUT      = (2 * TRIM >= SAMPLES) ? (SAMPLES - 1) / 2 : TRIM;
  localparam int KEPT     = SAMPLES - 2 * CUT;
  localparam int SEQ_LEN  = 4 * SAMPLES;
  localparam int ADC_MAX  = (1 << ADC_W) - 1;
  localparam int POS_MAX  = (1 << (XY_W - 1)) - 1;
  localparam int POS_MIN  = -(1 << (XY_W - 1));
  // drain, divide, calibrate and load for one sequence, four times for margin
  localparam int SETTLE_CYCLES = 4 * (SAMPLES + 6);
  localparam int WORD_TARGET   = 1450;
  localparam int HOLD_CYCLES   = 600;
  localparam int LIMIT_TICKS   = 2_000_000;

  typedef enum {SEQ_TIGHT, SEQ_ZERO, SEQ_FULL, SEQ_SPLIT, SEQ_NOISE} seq_kind_t;

  // --------------------------------------------------------------------------
  // Touch point model: own copy of the sample store, sequence position,
  // group means and registers. Predicted points queue up in points_due.
  // --------------------------------------------------------------------------
  class touch_point_tracker;
    logic [ADC_W-1:0]        bucket [SAMPLES];
    int                      taken;
    logic [ADC_W-1:0]        x1_mean, y1_mean, x2_mean;
    logic [GAIN_W-1:0]       gx, gy;
    logic signed [OFS_W-1:0] ox, oy;
    logic [ADC_W-1:0]        match_win;
    out_t                    points_due [$];
    int                      faults;
    int                      points_seen;

    function new();
      foreach (bucket[i]) bucket[i] = '0;
      taken       = 0;
      x1_mean     = '0;
      y1_mean     = '0;
      x2_mean     = '0;
      gx          = X_GAIN_RST;
      ox          = X_OFFSET_RST;
      gy          = Y_GAIN_RST;
      oy          = Y_OFFSET_RST;
      match_win   = AGREE_RST;
      faults      = 0;
      points_seen = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_X_GAIN:   gx = data[GAIN_W-1:0];
        REG_X_OFFSET: ox = data[OFS_W-1:0];
        REG_Y_GAIN:   gy = data[GAIN_W-1:0];
        REG_Y_OFFSET: oy = data[OFS_W-1:0];
        REG_AGREE:    match_win = data[ADC_W-1:0];
        default: ;
      endcase
    endfunction

    function int waiting();
      return points_due.size();
    endfunction

    // sort a copy, drop CUT from each end, floor mean of the rest
    function logic [ADC_W-1:0] trimmed_avg();
      int v [SAMPLES];
      int i, j, t, sum;
      for (i = 0; i < SAMPLES; i++) v[i] = bucket[i];
      for (i = 1; i < SAMPLES; i++) begin
        t = v[i];
        j = i;
        while (j > 0 && v[j-1] > t) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = t;
      end
      sum = 0;
      for (i = CUT; i < SAMPLES - CUT; i++) sum += v[i];
      return ADC_W'(sum / KEPT);
    endfunction

    function bit within_win(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
      int d;
      d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
      return d < int'(match_win);
    endfunction

    // Q2.14 gain, offset in whole units; truncate toward zero, saturate
    function logic signed [XY_W-1:0] to_screen(logic [GAIN_W-1:0] gain,
                                               logic signed [OFS_W-1:0] ofs,
                                               int adc);
      longint g, o, total, q;
      g = gain;
      o = ofs;
      total = g * longint'(adc) + (o <<< FRAC_W);
      q = total / (longint'(1) << FRAC_W);
      if (q > POS_MAX) q = POS_MAX;
      if (q < POS_MIN) q = POS_MIN;
      return q[XY_W-1:0];
    endfunction

    function void take_sample(in_t w);
      int               slot;
      logic [1:0]       grp;
      logic [ADC_W-1:0] m;
      int               xa, ya;
      out_t             pt;
      if (w.start_req) taken = 0;
      if (taken >= SEQ_LEN) taken = 0;
      slot = taken % SAMPLES;
      grp  = 2'(taken / SAMPLES);
      bucket[slot] = w.adc_sample;
      taken++;
      if (slot != SAMPLES - 1) return;
      m = trimmed_avg();
      case (grp)
        GRP_X1: x1_mean = m;
        GRP_Y1: y1_mean = m;
        GRP_X2: x2_mean = m;
        default: begin
          taken = 0;
          pt = '0;
          if (within_win(x1_mean, x2_mean) && within_win(y1_mean, m)) begin
            xa = (int'(x1_mean) + int'(x2_mean)) / 2;
            ya = (int'(y1_mean) + int'(m)) / 2;
            pt.agree = 1'b1;
            pt.x_adc = ADC_W'(xa);
            pt.y_adc = ADC_W'(ya);
            pt.x_pos = to_screen(gx, ox, xa);
            pt.y_pos = to_screen(gy, oy, ya);
          end
          points_due.push_back(pt);
        end
      endcase
    endfunction

    function void match_point(out_t got);
      out_t e;
      if (points_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("[%0t] result word with none expected: %p", $realtime, got);
        return;
      end
      e = points_due.pop_front();
      if (got.agree !== e.agree || got.x_adc !== e.x_adc || got.y_adc !== e.y_adc ||
          got.x_pos !== e.x_pos || got.y_pos !== e.y_pos) begin
        faults++;
        if (faults <= 10)
          $display("[%0t] point %0d: exp agree=%0b x_adc=%0d y_adc=%0d x_pos=%0d y_pos=%0d%s",
                   $realtime, points_seen, e.agree, e.x_adc, e.y_adc, e.x_pos, e.y_pos,
                   $sformatf(" / got agree=%0b x_adc=%0d y_adc=%0d x_pos=%0d y_pos=%0d",
                             got.agree, got.x_adc, got.y_adc, got.x_pos, got.y_pos));
      end
      points_seen++;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  touch_point_tracker board = new();
  int  words_sent = 0;
  int  burst_left = 0;
  bit  hold_done  = 1'b0;

  touch_trimmed_mean_calibrate #(
    .SAMPLES (SAMPLES),
    .TRIM    (TRIM)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(LIMIT_TICKS);
    $display("DONE: errors detected");
    $finish;
  end

  // result words taken at an edge with valid high and stall low
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.match_point(out_data);
  end

  // Receiver: its own stall pattern - free runs, random chatter, short and
  // longer holds - and once, after a couple of points, a long hold-off so the
  // result backs up and the block has to stall its sample input.
  initial begin
    int span;
    int pick;
    out_stall <= 1'b0;
    forever begin
      if (!hold_done && board.points_seen >= 2) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 50);
        repeat (span) @(posedge clk);
      end else if (pick <= 7) begin
        span = $urandom_range(1, 40);
        repeat (span) begin
          out_stall <= 1'($urandom_range(0, 1));
          @(posedge clk);
        end
      end else if (pick == 8) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 20);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        span = $urandom_range(30, 120);
        repeat (span) @(posedge clk);
      end
    end
  end

  // Offer one sample word and hold it until taken. The sender runs in
  // bursts; at the end of a burst valid drops for a random gap, with junk on
  // the payload meanwhile.
  task automatic send_word(input logic [ADC_W-1:0] sample, input logic restart);
    in_t w;
    int  gap;
    w.adc_sample = sample;
    w.start_req  = restart;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    board.take_sample(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      in_data  <= in_t'({12'($urandom), 1'($urandom)});
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 20);
    end
  endtask

  // register write; valid stays up for back-to-back writes, caller drops it
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
  endtask

  task automatic load_setting(input logic [CFG_W-1:0] xg, input logic [CFG_W-1:0] xo,
                              input logic [CFG_W-1:0] yg, input logic [CFG_W-1:0] yo,
                              input logic [CFG_W-1:0] win);
    write_reg(REG_X_GAIN,   xg);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_GAIN,   yg);
    write_reg(REG_Y_OFFSET, yo);
    write_reg(REG_AGREE,    win);
  endtask

  // level of a group: often pinned at an end of the ADC range
  function automatic int pick_level();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 0;
    if (r == 1) return ADC_MAX;
    return $urandom_range(0, ADC_MAX);
  endfunction

  // offset of the second reading from the first, sometimes none at all
  function automatic int drift();
    if ($urandom_range(0, 3) == 0) return 0;
    return int'($urandom_range(0, 120)) - 60;
  endfunction

  // One sequence of len words (SEQ_LEN when whole). Tight groups scatter
  // around a level with the odd wild outlier for the trim to remove.
  task automatic send_sequence(input seq_kind_t kind, input int len, input bit restart);
    int base [4];
    int spread, i, v;
    spread  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    base[0] = pick_level();
    base[1] = pick_level();
    base[2] = base[0] + drift();
    base[3] = base[1] + drift();
    if (kind == SEQ_SPLIT) begin
      if ($urandom_range(0, 1)) base[2] = ADC_MAX - base[0];
      else                      base[3] = ADC_MAX - base[1];
    end
    for (i = 0; i < len; i++) begin
      case (kind)
        SEQ_ZERO:  v = 0;
        SEQ_FULL:  v = ADC_MAX;
        SEQ_NOISE: v = $urandom_range(0, ADC_MAX);
        default: begin
          if ($urandom_range(0, 7) == 0) v = $urandom_range(0, ADC_MAX);
          else v = base[(i / SAMPLES) % 4] + int'($urandom_range(0, 2 * spread)) - spread;
        end
      endcase
      if (v < 0) v = 0;
      else if (v > ADC_MAX) v = ADC_MAX;
      send_word(ADC_W'(v), restart && (i == 0));
    end
  endtask

  initial begin
    int        phase;
    int        r, len, k;
    bit        broken, was_broken, restart;
    seq_kind_t kind;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_X_GAIN;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: a zero X group counted from reset, a full-scale Y group
    // running into the second X group, then a restart mid-group and
    // alternating bit patterns.
    send_sequence(SEQ_ZERO, SAMPLES, 1'b0);
    send_sequence(SEQ_FULL, SAMPLES + 2, 1'b0);
    send_word(ADC_W'(ADC_MAX), 1'b1);
    send_word(12'hAAA, 1'b0);
    send_word(12'h555, 1'b0);

    // Phases: reset values, all maxima, all minima (one-count window),
    // zero window, then random settings. Spare indexes must be ignored.
    phase      = 0;
    was_broken = 1'b1;
    while (words_sent < WORD_TARGET) begin
      if (phase > 0) begin
        in_valid <= 1'b0;
        while (board.waiting() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (phase == 1) begin
          load_setting(16'hFFFF, 16'h07FF, 16'hFFFF, 16'h07FF, 16'h0FFF);
        end else if (phase == 2) begin
          load_setting(16'h0000, 16'h0800, 16'h0000, 16'h0800, 16'h0001);
        end else if (phase == 3) begin
          load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'h0000);
        end else begin
          load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       ($urandom_range(0, 4) == 0) ? 16'($urandom)
                       : (16'($urandom_range(10, 300)) | (16'($urandom) & 16'hF000)));
          if (phase == 4) begin
            for (k = int'(REG_AGREE) + 1; k < (1 << IDX_W); k++)
              write_reg(IDX_W'(k), 16'($urandom));
          end
        end
        cfg_valid <= 1'b0;
      end

      repeat (4) begin
        r      = $urandom_range(0, 19);
        broken = (r >= 18);
        if (r <= 12 || broken) kind = SEQ_TIGHT;
        else if (r == 13)      kind = SEQ_ZERO;
        else if (r == 14)      kind = SEQ_FULL;
        else if (r <= 16)      kind = SEQ_SPLIT;
        else                   kind = SEQ_NOISE;
        len = broken ? $urandom_range(1, SEQ_LEN - 1) : SEQ_LEN;
        // after a broken sequence usually restart; otherwise only sometimes
        restart = was_broken ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 2) == 0);
        send_sequence(kind, len, restart);
        was_broken = broken;
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.faults == 0 && board.waiting() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ttmc_pkg.sv
rtl/ttmc_cell.sv
rtl/ttmc_div.sv
rtl/ttmc_calib.sv
rtl/touch_trimmed_mean_calibrate.sv
dv/tb_top.sv
